### hdl/cfcc_pkg.sv
package cfcc_pkg;

	localparam int MAX_TAPS      = 6;
	localparam int TAP_REGS      = 6;
	localparam int SAMPLE_BITS   = 16;
	localparam int TAP_BITS      = 16;
	localparam int FRAC_SHIFT    = 15;
	localparam int OUT_BITS      = 20;
	localparam int IDX_BITS      = 13;
	localparam int TCNT_BITS     = 3;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 32;

	localparam logic [IDX_BITS-1:0]      FRAME_LENGTH_RST = 13'd80;
	localparam logic [TCNT_BITS-1:0]     TAP_COUNT_RST    = 3'd1;
	localparam logic [CFG_DATA_BITS-1:0] TAP0_RST         = 32'h7FFF_0000;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_FRAME_LENGTH = 3'd0,
		REG_TAP_COUNT    = 3'd1,
		REG_TAP_0        = 3'd2,
		REG_TAP_1        = 3'd3,
		REG_TAP_2        = 3'd4,
		REG_TAP_3        = 3'd5,
		REG_TAP_4        = 3'd6,
		REG_TAP_5        = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_re;
		logic signed [SAMPLE_BITS-1:0] sample_im;
	} in_item_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] out_re;
		logic signed [OUT_BITS-1:0] out_im;
		logic                       frame_end;
	} out_item_t;

	typedef struct packed {
		logic [IDX_BITS-1:0]  frame_length;
		logic [TCNT_BITS-1:0] tap_count;
	} cfg_ctl_t;

endpackage

### hdl/cfcc_cfg.sv
module cfcc_cfg #(
	parameter int NUM_TAPS = cfcc_pkg::MAX_TAPS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [cfcc_pkg::CFG_IDX_BITS-1:0]    wr_index,
	input  logic [cfcc_pkg::CFG_DATA_BITS-1:0]   wr_data,
	output cfcc_pkg::cfg_ctl_t                   ctl,
	output logic [cfcc_pkg::CFG_DATA_BITS-1:0]   taps [NUM_TAPS]
);

	cfcc_pkg::cfg_ctl_t                 ctl_q;
	logic [cfcc_pkg::CFG_DATA_BITS-1:0] taps_q [NUM_TAPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.frame_length <= cfcc_pkg::FRAME_LENGTH_RST;
			ctl_q.tap_count    <= cfcc_pkg::TAP_COUNT_RST;
			for (int i = 0; i < NUM_TAPS; i++) begin
				taps_q[i] <= (i == 0) ? cfcc_pkg::TAP0_RST : '0;
			end
		end else if (wr_en) begin
			if (wr_index == cfcc_pkg::REG_FRAME_LENGTH) begin
				ctl_q.frame_length <= wr_data[cfcc_pkg::IDX_BITS-1:0];
			end
			if (wr_index == cfcc_pkg::REG_TAP_COUNT) begin
				ctl_q.tap_count <= wr_data[cfcc_pkg::TCNT_BITS-1:0];
			end
			for (int i = 0; i < NUM_TAPS; i++) begin
				if (wr_index == cfcc_pkg::CFG_IDX_BITS'(cfcc_pkg::REG_TAP_0)
					+ cfcc_pkg::CFG_IDX_BITS'(i)) begin
					taps_q[i] <= wr_data;
				end
			end
		end
	end

	assign ctl  = ctl_q;
	assign taps = taps_q;

endmodule

### hdl/cfcc_window.sv
module cfcc_window #(
	parameter int NUM_TAPS = cfcc_pkg::MAX_TAPS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  cfcc_pkg::in_item_t in_data,
	input  cfcc_pkg::cfg_ctl_t ctl,
	input  logic               down_ready,
	output logic               valid_s1,
	output cfcc_pkg::in_item_t win_s1 [NUM_TAPS],
	output logic               last_s1
);

	localparam int DL = (NUM_TAPS > 1) ? NUM_TAPS - 1 : 1;

	logic [cfcc_pkg::IDX_BITS-1:0] sample_index_q;
	cfcc_pkg::in_item_t            delay_q [DL];
	logic                          accept;
	logic                          last;

	assign in_ready = !valid_s1 || down_ready;
	assign accept   = in_valid && in_ready;
	assign last     = sample_index_q
		== (ctl.frame_length - cfcc_pkg::IDX_BITS'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_index_q <= '0;
			for (int i = 0; i < DL; i++) begin
				delay_q[i] <= '0;
			end
		end else if (accept) begin
			if (last) begin
				sample_index_q <= '0;
				for (int i = 0; i < DL; i++) begin
					delay_q[i] <= '0;
				end
			end else begin
				sample_index_q <= sample_index_q + cfcc_pkg::IDX_BITS'(1);
				for (int i = DL - 1; i > 0; i--) begin
					delay_q[i] <= delay_q[i-1];
				end
				delay_q[0] <= in_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// lanes past tap_count carry zero
	always_ff @(posedge clk) begin
		if (in_ready) begin
			last_s1   <= last;
			win_s1[0] <= (ctl.tap_count != '0) ? in_data : '0;
		end
	end

	for (genvar j = 1; j < NUM_TAPS; j++) begin : g_lane
		always_ff @(posedge clk) begin
			if (in_ready) begin
				win_s1[j] <= (int'(ctl.tap_count) > j) ? delay_q[j-1] : '0;
			end
		end
	end

endmodule

### hdl/cfcc_mac.sv
module cfcc_mac #(
	parameter int NUM_TAPS = cfcc_pkg::MAX_TAPS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               valid_s1,
	input  cfcc_pkg::in_item_t                 win_s1 [NUM_TAPS],
	input  logic                               last_s1,
	input  logic [cfcc_pkg::CFG_DATA_BITS-1:0] taps [NUM_TAPS],
	output logic                               s2_ready,
	output logic                               out_valid,
	input  logic                               out_ready,
	output cfcc_pkg::out_item_t                out_data
);

	localparam int PW    = cfcc_pkg::SAMPLE_BITS + cfcc_pkg::TAP_BITS + 1;
	localparam int TOP_W = cfcc_pkg::FRAC_SHIFT + cfcc_pkg::OUT_BITS;
	localparam int SUM_W = PW + $clog2(NUM_TAPS + 1);
	localparam int ACC_W = (SUM_W > TOP_W) ? SUM_W : TOP_W;

	logic signed [PW-1:0]    lane_re_s2 [NUM_TAPS];
	logic signed [PW-1:0]    lane_im_s2 [NUM_TAPS];
	logic                    valid_s2;
	logic                    last_s2;
	logic                    valid_s3;
	cfcc_pkg::out_item_t     data_s3;
	logic                    s3_ready;
	logic signed [ACC_W-1:0] acc_re;
	logic signed [ACC_W-1:0] acc_im;

	assign s3_ready = !valid_s3 || out_ready;
	assign s2_ready = !valid_s2 || s3_ready;

	for (genvar j = 0; j < NUM_TAPS; j++) begin : g_lane
		logic signed [cfcc_pkg::TAP_BITS-1:0] h_re;
		logic signed [cfcc_pkg::TAP_BITS-1:0] h_im;
		logic signed [PW-1:0]                 p_rr;
		logic signed [PW-1:0]                 p_ii;
		logic signed [PW-1:0]                 p_ri;
		logic signed [PW-1:0]                 p_ir;

		assign h_re = taps[j][2*cfcc_pkg::TAP_BITS-1:cfcc_pkg::TAP_BITS];
		assign h_im = taps[j][cfcc_pkg::TAP_BITS-1:0];
		assign p_rr = win_s1[j].sample_re * h_re;
		assign p_ii = win_s1[j].sample_im * h_im;
		assign p_ri = win_s1[j].sample_re * h_im;
		assign p_ir = win_s1[j].sample_im * h_re;

		always_ff @(posedge clk) begin
			if (s2_ready) begin
				lane_re_s2[j] <= p_rr - p_ii;
				lane_im_s2[j] <= p_ri + p_ir;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready) begin
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
			if (s3_ready) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_comb begin
		acc_re = '0;
		acc_im = '0;
		for (int j = 0; j < NUM_TAPS; j++) begin
			acc_re = acc_re + ACC_W'(lane_re_s2[j]);
			acc_im = acc_im + ACC_W'(lane_im_s2[j]);
		end
	end

	// floor shift, then wrap to output width
	always_ff @(posedge clk) begin
		if (s3_ready) begin
			data_s3.out_re    <= acc_re[cfcc_pkg::FRAC_SHIFT +: cfcc_pkg::OUT_BITS];
			data_s3.out_im    <= acc_im[cfcc_pkg::FRAC_SHIFT +: cfcc_pkg::OUT_BITS];
			data_s3.frame_end <= last_s2;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;

endmodule

### hdl/complex_fir_channel_convolver.sv
// Path: the item passes the window, lane product and sum registers in turn,
// the first loaded at the accepting edge; out_valid follows the sum register.
// Throughput: one item per cycle unless stalled, set by one complex multiply lane per tap.
// A stalled output holds the pipeline; empty stages still fill behind it.
// Reset: delay line and sample counter zero, pipeline empty, registers at
// frame_length 80, tap_count 1, tap_0 0x7FFF0000, other taps zero.
module complex_fir_channel_convolver #(
	parameter int MAX_TAPS = cfcc_pkg::MAX_TAPS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  cfcc_pkg::in_item_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output cfcc_pkg::out_item_t                out_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [cfcc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [cfcc_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	localparam int NUM_TAPS = (MAX_TAPS < cfcc_pkg::TAP_REGS) ? MAX_TAPS
		: cfcc_pkg::TAP_REGS;

	cfcc_pkg::cfg_ctl_t                 ctl;
	logic [cfcc_pkg::CFG_DATA_BITS-1:0] taps [NUM_TAPS];
	logic                               valid_s1;
	cfcc_pkg::in_item_t                 win_s1 [NUM_TAPS];
	logic                               last_s1;
	logic                               s2_ready;

	assign cfg_ready = 1'b1;

	cfcc_cfg #(
		.NUM_TAPS (NUM_TAPS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.ctl      (ctl),
		.taps     (taps)
	);

	cfcc_window #(
		.NUM_TAPS (NUM_TAPS)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.ctl        (ctl),
		.down_ready (s2_ready),
		.valid_s1   (valid_s1),
		.win_s1     (win_s1),
		.last_s1    (last_s1)
	);

	cfcc_mac #(
		.NUM_TAPS (NUM_TAPS)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.win_s1    (win_s1),
		.last_s1   (last_s1),
		.taps      (taps),
		.s2_ready  (s2_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
